// ===== src/sls_pkg.sv =====
// sls_pkg: request codes, sort keys and sequencer states of the string list sorter
// no dependencies
package sls_pkg;

  typedef enum logic [2:0] {
    REQ_LOAD  = 3'd0,
    REQ_CLOSE = 3'd1,
    REQ_SORT  = 3'd2,
    REQ_READ  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    KEY_ORIG  = 2'd0,
    KEY_BYTES = 2'd1,
    KEY_LEN   = 2'd2,
    KEY_WORD  = 2'd3
  } key_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOADI,
    ST_KSTART,
    ST_CA,
    ST_CB,
    ST_CCMP,
    ST_SWAP,
    ST_WI
  } state_t;

  localparam logic [7:0] NUL_CHAR = 8'h00;

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

// ===== src/sls_in_if.sv =====
// sls_in_if: request channel, valid/ready with one request per beat
// depends on nothing
interface sls_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] char_in;
  logic [1:0] sort_key;

  modport source (output valid, req_type, char_in, sort_key, input ready);
  modport sink   (input valid, req_type, char_in, sort_key, output ready);
endinterface

// ===== src/sls_out_if.sv =====
// sls_out_if: result channel, valid/ready with one character per beat
// depends on nothing
interface sls_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       end_of_text;
  logic       empty_text;
  logic       list_done;
  logic       nothing_left;

  modport source (output valid, char_out, end_of_text, empty_text, list_done,
                  nothing_left, input ready);
  modport sink   (input valid, char_out, end_of_text, empty_text, list_done,
                  nothing_left, output ready);
endinterface

// ===== src/string_list_key_sorter_top.sv =====
// string_list_key_sorter_top: request decode, sort sequencer and read-out
// depends on sls_pkg, sls_in_if, sls_out_if, sls_char_mem, sls_text_table
// Load, close, clear and sort-by-original complete in the idle state; a read moves to the
// read state, which holds off the input, and its result beat is registered from there, later
// while the output register waits. A sort by key walks i<k pairs: length and first word
// length keys compare the stored lengths, byte collation compares byte by byte until a
// difference or until the shorter string runs out, and then compares the string lengths.
// Reset clears counters, read position and sequencer; stores are undefined until written.
module string_list_key_sorter_top #(
  parameter int MAX_TEXTS    = 16,
  parameter int MAX_TEXT_LEN = 64
) (
  input  logic clk,
  input  logic rst_n,
  sls_in_if.sink    in_ch,
  sls_out_if.source out_ch
);

  localparam int IW  = $clog2(MAX_TEXTS);
  localparam int CW  = $clog2(MAX_TEXTS + 1);
  localparam int OFW = $clog2(MAX_TEXT_LEN);
  localparam int LW  = $clog2(MAX_TEXT_LEN + 1);
  localparam int AW  = IW + OFW;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TEXTS);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TEXT_LEN);

  sls_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, rank_r, i_r, k_r;
  logic [LW-1:0] fill_r, offset_r, fw_len_r, p_r;
  logic          fw_started_r, fw_done_r, orig_r;
  logic [1:0]    key_r;
  logic [IW-1:0] a_r, b_r;
  logic [LW-1:0] la_r, fa_r, lb_r, fb_r;
  logic [7:0]    ca_r;
  logic          gt_r;

  // pending read result
  logic rd_mem_r, rd_end_r, rd_empty_r, rd_done_r, rd_none_r;
  logic [AW-1:0] rd_addr_r;

  // output register
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_end_r, out_empty_r, out_done_r, out_none_r;

  // memory and table ports
  logic          cm_we;
  logic [AW-1:0] cm_wa, cm_ra;
  logic [7:0]    cm_rd;
  logic          info_we, ord_we;
  logic [IW-1:0] tw_addr, tw_ord, ord_ra, ord_rd, tab_ra;
  logic [LW-1:0] len_rd, fwl_rd;

  logic          acc;
  sls_pkg::req_t req;
  logic          rd_left, rd_nomem, rd_last;
  logic [IW-1:0] rd_idx;
  logic [LW-1:0] min_len;

  assign acc = in_ch.valid && in_ch.ready;
  assign req = sls_pkg::req_t'(in_ch.req_type);
  assign in_ch.ready = (state_r == sls_pkg::ST_IDLE);

  sls_char_mem #(.AW(AW)) u_mem (
    .clk(clk), .wr_en(cm_we), .wr_addr(cm_wa), .wr_data(in_ch.char_in),
    .rd_addr(cm_ra), .rd_data(cm_rd)
  );

  sls_text_table #(.IW(IW), .LW(LW)) u_tab (
    .clk(clk), .info_we(info_we), .ord_we(ord_we), .wr_addr(tw_addr),
    .wr_len(fill_r), .wr_fwl(fw_len_r), .wr_ord(tw_ord),
    .ord_rd_addr(ord_ra), .ord_rd_data(ord_rd),
    .tab_rd_addr(tab_ra), .len_rd(len_rd), .fwl_rd(fwl_rd)
  );

  // read decode
  assign rd_left  = (rank_r < count_r);
  assign rd_idx   = orig_r ? rank_r[IW-1:0] : ord_rd;
  assign rd_nomem = (len_rd == '0) || (offset_r >= len_rd);
  assign rd_last  = ({1'b0, rank_r} + (CW+1)'(1)) == {1'b0, count_r};
  assign min_len  = (la_r < lb_r) ? la_r : lb_r;

  // memory and table addressing
  always_comb begin
    cm_we   = 1'b0;
    cm_wa   = {count_r[IW-1:0], fill_r[OFW-1:0]};
    cm_ra   = {rd_idx, offset_r[OFW-1:0]};
    info_we = 1'b0;
    ord_we  = 1'b0;
    tw_addr = count_r[IW-1:0];
    tw_ord  = count_r[IW-1:0];
    ord_ra  = rank_r[IW-1:0];
    tab_ra  = rd_idx;
    case (state_r)
      sls_pkg::ST_IDLE: begin
        if (acc && req == sls_pkg::REQ_LOAD && in_ch.char_in != sls_pkg::NUL_CHAR
            && count_r < CNT_MAX && fill_r < LEN_MAX) begin
          cm_we = 1'b1;
        end
        if (acc && req == sls_pkg::REQ_CLOSE && count_r < CNT_MAX) begin
          info_we = 1'b1;
          ord_we  = 1'b1;
        end
      end
      // hold the read address so the character stays put while the output waits
      sls_pkg::ST_READ: cm_ra = rd_addr_r;
      sls_pkg::ST_LOADI: begin
        ord_ra = i_r[IW-1:0];
        tab_ra = ord_rd;
      end
      sls_pkg::ST_KSTART: begin
        ord_ra = k_r[IW-1:0];
        tab_ra = ord_rd;
      end
      sls_pkg::ST_CA: cm_ra = {a_r, p_r[OFW-1:0]};
      sls_pkg::ST_CB: cm_ra = {b_r, p_r[OFW-1:0]};
      sls_pkg::ST_SWAP: begin
        ord_we  = gt_r;
        tw_addr = k_r[IW-1:0];
        tw_ord  = a_r;
      end
      sls_pkg::ST_WI: begin
        ord_we  = 1'b1;
        tw_addr = i_r[IW-1:0];
        tw_ord  = a_r;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sls_pkg::ST_IDLE: begin
        if (acc && req == sls_pkg::REQ_READ) begin
          state_nxt = sls_pkg::ST_READ;
        end else if (acc && req == sls_pkg::REQ_SORT && in_ch.sort_key != sls_pkg::KEY_ORIG
                     && count_r >= CW'(2)) begin
          state_nxt = sls_pkg::ST_LOADI;
        end
      end
      sls_pkg::ST_READ:   if (!out_valid_r || out_ch.ready) state_nxt = sls_pkg::ST_IDLE;
      sls_pkg::ST_LOADI:  state_nxt = sls_pkg::ST_KSTART;
      sls_pkg::ST_KSTART: state_nxt = (key_r == sls_pkg::KEY_BYTES) ? sls_pkg::ST_CA
                                                                     : sls_pkg::ST_SWAP;
      sls_pkg::ST_CA:     state_nxt = (p_r == min_len) ? sls_pkg::ST_SWAP : sls_pkg::ST_CB;
      sls_pkg::ST_CB:     state_nxt = sls_pkg::ST_CCMP;
      sls_pkg::ST_CCMP:   state_nxt = (ca_r != cm_rd) ? sls_pkg::ST_SWAP : sls_pkg::ST_CA;
      sls_pkg::ST_SWAP: begin
        if (({1'b0, k_r} + (CW+1)'(1)) == {1'b0, count_r}) state_nxt = sls_pkg::ST_WI;
        else state_nxt = sls_pkg::ST_KSTART;
      end
      sls_pkg::ST_WI: begin
        if (({1'b0, i_r} + (CW+1)'(2)) >= {1'b0, count_r}) state_nxt = sls_pkg::ST_IDLE;
        else state_nxt = sls_pkg::ST_LOADI;
      end
      default: state_nxt = sls_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sls_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // list control and read position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      fill_r       <= '0;
      rank_r       <= '0;
      offset_r     <= '0;
      orig_r       <= 1'b0;
      fw_len_r     <= '0;
      fw_started_r <= 1'b0;
      fw_done_r    <= 1'b0;
    end else if (acc) begin
      case (req)
        sls_pkg::REQ_LOAD: begin
          if (cm_we) begin
            fill_r <= fill_r + LW'(1);
            if (!fw_done_r) begin
              if (sls_pkg::is_blank(in_ch.char_in)) begin
                if (fw_started_r) fw_done_r <= 1'b1;
              end else begin
                fw_len_r     <= fw_len_r + LW'(1);
                fw_started_r <= 1'b1;
              end
            end
          end
        end
        sls_pkg::REQ_CLOSE: begin
          if (count_r < CNT_MAX) begin
            count_r      <= count_r + CW'(1);
            fill_r       <= '0;
            fw_len_r     <= '0;
            fw_started_r <= 1'b0;
            fw_done_r    <= 1'b0;
          end
        end
        sls_pkg::REQ_SORT: begin
          rank_r   <= '0;
          offset_r <= '0;
          orig_r   <= (in_ch.sort_key == sls_pkg::KEY_ORIG);
        end
        sls_pkg::REQ_READ: begin
          if (rd_left) begin
            if (rd_nomem || (offset_r + LW'(1)) == len_rd) begin
              rank_r   <= rank_r + CW'(1);
              offset_r <= '0;
            end else begin
              offset_r <= offset_r + LW'(1);
            end
          end
        end
        sls_pkg::REQ_CLEAR: begin
          count_r      <= '0;
          fill_r       <= '0;
          rank_r       <= '0;
          offset_r     <= '0;
          orig_r       <= 1'b0;
          fw_len_r     <= '0;
          fw_started_r <= 1'b0;
          fw_done_r    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // read beat decode into the pending result
  always_ff @(posedge clk) begin
    if (state_r == sls_pkg::ST_IDLE && acc && req == sls_pkg::REQ_READ) begin
      rd_addr_r  <= cm_ra;
      rd_none_r  <= !rd_left;
      rd_mem_r   <= rd_left && !rd_nomem;
      rd_empty_r <= rd_left && (len_rd == '0);
      rd_end_r   <= rd_left && (rd_nomem || (offset_r + LW'(1)) == len_rd);
      rd_done_r  <= rd_left && rd_last && (rd_nomem || (offset_r + LW'(1)) == len_rd);
    end
  end

  // sort datapath
  always_ff @(posedge clk) begin
    case (state_r)
      sls_pkg::ST_IDLE: begin
        key_r <= in_ch.sort_key;
        i_r   <= '0;
        k_r   <= CW'(1);
      end
      sls_pkg::ST_LOADI: begin
        a_r  <= ord_rd;
        la_r <= len_rd;
        fa_r <= fwl_rd;
      end
      sls_pkg::ST_KSTART: begin
        b_r  <= ord_rd;
        lb_r <= len_rd;
        fb_r <= fwl_rd;
        p_r  <= '0;
        gt_r <= (key_r == sls_pkg::KEY_LEN) ? (la_r > len_rd) : (fa_r > fwl_rd);
      end
      sls_pkg::ST_CA: if (p_r == min_len) gt_r <= (la_r > lb_r);
      sls_pkg::ST_CB: ca_r <= cm_rd;
      sls_pkg::ST_CCMP: begin
        if (ca_r != cm_rd) gt_r <= (ca_r > cm_rd);
        else p_r <= p_r + LW'(1);
      end
      sls_pkg::ST_SWAP: begin
        if (gt_r) begin
          a_r  <= b_r;
          la_r <= lb_r;
          fa_r <= fb_r;
        end
        k_r <= k_r + CW'(1);
      end
      sls_pkg::ST_WI: begin
        i_r <= i_r + CW'(1);
        k_r <= i_r + CW'(2);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sls_pkg::ST_READ && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sls_pkg::ST_READ && (!out_valid_r || out_ch.ready)) begin
      out_char_r  <= rd_mem_r ? cm_rd : sls_pkg::NUL_CHAR;
      out_end_r   <= rd_end_r;
      out_empty_r <= rd_empty_r;
      out_done_r  <= rd_done_r;
      out_none_r  <= rd_none_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.char_out     = out_char_r;
  assign out_ch.end_of_text  = out_end_r;
  assign out_ch.empty_text   = out_empty_r;
  assign out_ch.list_done    = out_done_r;
  assign out_ch.nothing_left = out_none_r;

endmodule

// ===== src/sls_char_mem.sv =====
// sls_char_mem: character store, one write and one registered read port
// no dependencies
module sls_char_mem #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/sls_text_table.sv =====
// sls_text_table: per string length, first word length and working order
// no dependencies
module sls_text_table #(
  parameter int IW = 4,
  parameter int LW = 7
) (
  input  logic          clk,
  input  logic          info_we,
  input  logic          ord_we,
  input  logic [IW-1:0] wr_addr,
  input  logic [LW-1:0] wr_len,
  input  logic [LW-1:0] wr_fwl,
  input  logic [IW-1:0] wr_ord,
  input  logic [IW-1:0] ord_rd_addr,
  output logic [IW-1:0] ord_rd_data,
  input  logic [IW-1:0] tab_rd_addr,
  output logic [LW-1:0] len_rd,
  output logic [LW-1:0] fwl_rd
);

  logic [LW-1:0] len_q   [2**IW];
  logic [LW-1:0] fwl_q   [2**IW];
  logic [IW-1:0] order_q [2**IW];

  // writes from close and from the sort swaps
  always_ff @(posedge clk) begin
    if (info_we) begin
      len_q[wr_addr] <= wr_len;
      fwl_q[wr_addr] <= wr_fwl;
    end
    if (ord_we) begin
      order_q[wr_addr] <= wr_ord;
    end
  end

  // combinational reads, one address for the order and one for the lengths
  assign ord_rd_data = order_q[ord_rd_addr];
  assign len_rd      = len_q[tab_rd_addr];
  assign fwl_rd      = fwl_q[tab_rd_addr];

endmodule
